// File: rtl/triangle_face_normal_macros.svh
// assertion macros shared by the checker
`ifndef TRIANGLE_FACE_NORMAL_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define TFN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tfn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

	localparam int COORD_BITS = 24;
	localparam int LANES      = 3;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int KEEP_BITS  = 30;
	localparam int U2_W       = 2 * KEEP_BITS;
	localparam int SUM_W      = U2_W + 2;
	localparam int QUO_W      = KEEP_BITS + 1;
	localparam int ROOT_W     = (QUO_W + 1) / 2;
	localparam int SH_W       = $clog2(CROSS_W + 1);
	localparam int OUT_W      = 16;

	// sideband that rides along with each word
	typedef struct packed {
		logic             last;
		logic             degen;
		logic [LANES-1:0] neg;
	} meta_t;

endpackage

`default_nettype wire

// File: rtl/tfn_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tfn_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                adv,
	input  wire logic                                in_valid,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] ax,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] ay,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] az,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] bx,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] by,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] bz,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] cx,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] cy,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] cz,
	input  wire logic                                last_triangle,
	output logic                                     out_valid,
	output tfn_pkg::meta_t                           out_meta,
	output logic [tfn_pkg::SUM_W-1:0]                out_s,
	output logic [tfn_pkg::U2_W-1:0]                 out_u2 [tfn_pkg::LANES]
);

	logic [8:1] vld_s;

	logic signed [tfn_pkg::DIFF_W-1:0]  d1_s1 [tfn_pkg::LANES];
	logic signed [tfn_pkg::DIFF_W-1:0]  d2_s1 [tfn_pkg::LANES];
	logic signed [tfn_pkg::PROD_W-1:0]  p_s2 [6];
	logic signed [tfn_pkg::CROSS_W-1:0] c_s3 [tfn_pkg::LANES];
	logic [tfn_pkg::CROSS_W-1:0]        mag_s4 [tfn_pkg::LANES];
	logic [tfn_pkg::CROSS_W-1:0]        mag_s5 [tfn_pkg::LANES];
	logic [tfn_pkg::SH_W-1:0]           sh_s5;
	logic [tfn_pkg::KEEP_BITS-1:0]      u_s6 [tfn_pkg::LANES];
	logic [tfn_pkg::U2_W-1:0]           u2_s7 [tfn_pkg::LANES];
	logic [tfn_pkg::U2_W-1:0]           u2_s8 [tfn_pkg::LANES];
	logic [tfn_pkg::SUM_W-1:0]          s_s8;
	logic                               last_s1, last_s2, last_s3;
	tfn_pkg::meta_t                     meta_s4, meta_s5, meta_s6, meta_s7, meta_s8;

	logic [tfn_pkg::CROSS_W-1:0] mag_c [tfn_pkg::LANES];
	logic [tfn_pkg::LANES-1:0]   neg_c;
	logic [tfn_pkg::CROSS_W-1:0] orv_c;
	logic [tfn_pkg::SH_W-1:0]    len_c;
	logic [tfn_pkg::SH_W-1:0]    sh_c;

	// magnitude and sign of each cross component
	always_comb begin
		for (int l = 0; l < tfn_pkg::LANES; l++) begin
			neg_c[l] = c_s3[l][tfn_pkg::CROSS_W-1];
			mag_c[l] = neg_c[l] ? (tfn_pkg::CROSS_W'(0) - c_s3[l]) : c_s3[l];
		end
	end

	// bit length of the largest magnitude, and the shift down to KEEP_BITS
	always_comb begin
		orv_c = mag_s4[0] | mag_s4[1] | mag_s4[2];
		len_c = '0;
		for (int i = 0; i < tfn_pkg::CROSS_W; i++) begin
			if (orv_c[i]) begin
				len_c = tfn_pkg::SH_W'(i + 1);
			end
		end
		sh_c = (len_c > tfn_pkg::SH_W'(tfn_pkg::KEEP_BITS))
			? (len_c - tfn_pkg::SH_W'(tfn_pkg::KEEP_BITS)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[7:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// edge vectors a-b and b-c
			d1_s1[0] <= tfn_pkg::DIFF_W'(ax) - tfn_pkg::DIFF_W'(bx);
			d1_s1[1] <= tfn_pkg::DIFF_W'(ay) - tfn_pkg::DIFF_W'(by);
			d1_s1[2] <= tfn_pkg::DIFF_W'(az) - tfn_pkg::DIFF_W'(bz);
			d2_s1[0] <= tfn_pkg::DIFF_W'(bx) - tfn_pkg::DIFF_W'(cx);
			d2_s1[1] <= tfn_pkg::DIFF_W'(by) - tfn_pkg::DIFF_W'(cy);
			d2_s1[2] <= tfn_pkg::DIFF_W'(bz) - tfn_pkg::DIFF_W'(cz);
			last_s1  <= last_triangle;

			// cross product terms
			p_s2[0] <= d1_s1[1] * d2_s1[2];
			p_s2[1] <= d1_s1[2] * d2_s1[1];
			p_s2[2] <= d1_s1[2] * d2_s1[0];
			p_s2[3] <= d1_s1[0] * d2_s1[2];
			p_s2[4] <= d1_s1[0] * d2_s1[1];
			p_s2[5] <= d1_s1[1] * d2_s1[0];
			last_s2 <= last_s1;

			c_s3[0] <= tfn_pkg::CROSS_W'(p_s2[0]) - tfn_pkg::CROSS_W'(p_s2[1]);
			c_s3[1] <= tfn_pkg::CROSS_W'(p_s2[2]) - tfn_pkg::CROSS_W'(p_s2[3]);
			c_s3[2] <= tfn_pkg::CROSS_W'(p_s2[4]) - tfn_pkg::CROSS_W'(p_s2[5]);
			last_s3 <= last_s2;

			mag_s4        <= mag_c;
			meta_s4.last  <= last_s3;
			meta_s4.degen <= 1'b0;
			meta_s4.neg   <= neg_c;

			mag_s5        <= mag_s4;
			sh_s5         <= sh_c;
			meta_s5.last  <= meta_s4.last;
			meta_s5.neg   <= meta_s4.neg;
			meta_s5.degen <= (orv_c == '0);

			for (int l = 0; l < tfn_pkg::LANES; l++) begin
				u_s6[l]  <= tfn_pkg::KEEP_BITS'(mag_s5[l] >> sh_s5);
				u2_s7[l] <= u_s6[l] * u_s6[l];
			end
			meta_s6 <= meta_s5;
			meta_s7 <= meta_s6;

			s_s8 <= tfn_pkg::SUM_W'(u2_s7[0]) + tfn_pkg::SUM_W'(u2_s7[1])
				+ tfn_pkg::SUM_W'(u2_s7[2]);
			u2_s8   <= u2_s7;
			meta_s8 <= meta_s7;
		end
	end

	assign out_valid = vld_s[8];
	assign out_meta  = meta_s8;
	assign out_s     = s_s8;
	assign out_u2    = u2_s8;

endmodule

`default_nettype wire

// File: rtl/tfn_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per stage: q = (u2 << KEEP_BITS) / s
module tfn_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire tfn_pkg::meta_t               in_meta,
	input  wire logic [tfn_pkg::SUM_W-1:0]    in_s,
	input  wire logic [tfn_pkg::U2_W-1:0]     in_u2 [tfn_pkg::LANES],
	output logic                              out_valid,
	output tfn_pkg::meta_t                    out_meta,
	output logic [tfn_pkg::QUO_W-1:0]         out_q [tfn_pkg::LANES]
);

	localparam int N = tfn_pkg::QUO_W;
	localparam int W = tfn_pkg::SUM_W;

	logic [N:1]          vld_s;
	tfn_pkg::meta_t      meta_s [1:N];
	logic [W-1:0]        s_s    [1:N];
	logic [W-1:0]        rem_s  [1:N][tfn_pkg::LANES];
	logic [N-1:0]        q_s    [1:N][tfn_pkg::LANES];

	logic                vld_c  [N];
	tfn_pkg::meta_t      meta_c [N];
	logic [W-1:0]        s_c    [N];
	logic [W-1:0]        rem_c  [N][tfn_pkg::LANES];
	logic [N-1:0]        q_c    [N][tfn_pkg::LANES];
	logic                bit_c  [N][tfn_pkg::LANES];

	// stage inputs: the first takes the port, the rest their register
	always_comb begin
		vld_c[0]  = in_valid;
		meta_c[0] = in_meta;
		s_c[0]    = in_s;
		for (int l = 0; l < tfn_pkg::LANES; l++) begin
			rem_c[0][l] = W'(in_u2[l] >> 1);
			q_c[0][l]   = '0;
			bit_c[0][l] = in_u2[l][0];
		end
		for (int j = 1; j < N; j++) begin
			vld_c[j]  = vld_s[j];
			meta_c[j] = meta_s[j];
			s_c[j]    = s_s[j];
			for (int l = 0; l < tfn_pkg::LANES; l++) begin
				rem_c[j][l] = rem_s[j][l];
				q_c[j][l]   = q_s[j][l];
				bit_c[j][l] = 1'b0;
			end
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [W:0]   trial [tfn_pkg::LANES];
		logic         ge    [tfn_pkg::LANES];
		logic [W-1:0] nrem  [tfn_pkg::LANES];

		always_comb begin
			for (int l = 0; l < tfn_pkg::LANES; l++) begin
				trial[l] = {rem_c[j][l], bit_c[j][l]};
				ge[l]    = (trial[l] >= {1'b0, s_c[j]});
				nrem[l]  = ge[l] ? W'(trial[l] - {1'b0, s_c[j]}) : W'(trial[l]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_c[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				meta_s[j+1] <= meta_c[j];
				s_s[j+1]    <= s_c[j];
				for (int l = 0; l < tfn_pkg::LANES; l++) begin
					rem_s[j+1][l] <= nrem[l];
					q_s[j+1][l]   <= {q_c[j][l][N-2:0], ge[l]};
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_meta  = meta_s[N];
	assign out_q     = q_s[N];

endmodule

`default_nettype wire

// File: rtl/tfn_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// integer square root, one result bit per stage, msb first
module tfn_sqrt (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         adv,
	input  wire logic                         in_valid,
	input  wire tfn_pkg::meta_t               in_meta,
	input  wire logic [tfn_pkg::QUO_W-1:0]    in_q [tfn_pkg::LANES],
	output logic                              out_valid,
	output tfn_pkg::meta_t                    out_meta,
	output logic [tfn_pkg::ROOT_W-1:0]        out_r [tfn_pkg::LANES]
);

	localparam int N = tfn_pkg::ROOT_W;

	logic [N:1]                     vld_s;
	tfn_pkg::meta_t                 meta_s [1:N];
	logic [tfn_pkg::QUO_W-1:0]      q_s    [1:N][tfn_pkg::LANES];
	logic [N-1:0]                   r_s    [1:N][tfn_pkg::LANES];

	logic                           vld_c  [N];
	tfn_pkg::meta_t                 meta_c [N];
	logic [tfn_pkg::QUO_W-1:0]      q_c    [N][tfn_pkg::LANES];
	logic [N-1:0]                   r_c    [N][tfn_pkg::LANES];

	always_comb begin
		vld_c[0]  = in_valid;
		meta_c[0] = in_meta;
		for (int l = 0; l < tfn_pkg::LANES; l++) begin
			q_c[0][l] = in_q[l];
			r_c[0][l] = '0;
		end
		for (int j = 1; j < N; j++) begin
			vld_c[j]  = vld_s[j];
			meta_c[j] = meta_s[j];
			for (int l = 0; l < tfn_pkg::LANES; l++) begin
				q_c[j][l] = q_s[j][l];
				r_c[j][l] = r_s[j][l];
			end
		end
	end

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [N-1:0]   trial [tfn_pkg::LANES];
		logic [2*N-1:0] sq    [tfn_pkg::LANES];
		logic           keep  [tfn_pkg::LANES];

		// try setting this stage's bit, keep it if trial^2 stays within q
		always_comb begin
			for (int l = 0; l < tfn_pkg::LANES; l++) begin
				trial[l] = r_c[j][l] | (N'(1) << (N - 1 - j));
				sq[l]    = trial[l] * trial[l];
				keep[l]  = (sq[l] <= (2*N)'(q_c[j][l]));
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_c[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				meta_s[j+1] <= meta_c[j];
				for (int l = 0; l < tfn_pkg::LANES; l++) begin
					q_s[j+1][l] <= q_c[j][l];
					r_s[j+1][l] <= keep[l] ? trial[l] : r_c[j][l];
				end
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_meta  = meta_s[N];
	assign out_r     = r_s[N];

endmodule

`default_nettype wire

// File: rtl/triangle_face_normal.sv
// throughput: one triangle per cycle; the 31-stage divider and 16-stage root
//   pipelines take a new word every cycle, stalls freeze the whole pipe
// reset: arst_n clears every valid bit at once, so the pipe comes up empty;
//   data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// triangle channel
	input  wire logic                                  tri_valid,
	output logic                                       tri_stall,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] ax,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] ay,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] az,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] bx,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] by,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] bz,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] cx,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] cy,
	input  wire logic signed [tfn_pkg::COORD_BITS-1:0] cz,
	input  wire logic                                  last_triangle,
	// normal channel
	output logic                                       nrm_valid,
	input  wire logic                                  nrm_stall,
	output logic signed [tfn_pkg::OUT_W-1:0]           normal_x,
	output logic signed [tfn_pkg::OUT_W-1:0]           normal_y,
	output logic signed [tfn_pkg::OUT_W-1:0]           normal_z,
	output logic                                       degenerate,
	output logic                                       last_normal
);

	// the whole pipe moves unless a finished word sits unread at the output
	logic adv;

	logic                          fr_valid;
	tfn_pkg::meta_t                fr_meta;
	logic [tfn_pkg::SUM_W-1:0]     fr_s;
	logic [tfn_pkg::U2_W-1:0]      fr_u2 [tfn_pkg::LANES];

	logic                          dv_valid;
	tfn_pkg::meta_t                dv_meta;
	logic [tfn_pkg::QUO_W-1:0]     dv_q [tfn_pkg::LANES];

	logic                          sq_valid;
	tfn_pkg::meta_t                sq_meta;
	logic [tfn_pkg::ROOT_W-1:0]    sq_r [tfn_pkg::LANES];

	logic [tfn_pkg::ROOT_W:0]      rnd_c [tfn_pkg::LANES];
	logic [tfn_pkg::OUT_W-1:0]     nrm_c [tfn_pkg::LANES];

	logic                          vld_q;
	logic [tfn_pkg::OUT_W-1:0]     nx_q, ny_q, nz_q;
	logic                          degen_q, last_q;

	assign adv       = !(vld_q && nrm_stall);
	assign tri_stall = !adv;

	// differences, cross product, normalizing shift, sum of squares
	tfn_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (tri_valid),
		.ax            (ax),
		.ay            (ay),
		.az            (az),
		.bx            (bx),
		.by            (by),
		.bz            (bz),
		.cx            (cx),
		.cy            (cy),
		.cz            (cz),
		.last_triangle (last_triangle),
		.out_valid     (fr_valid),
		.out_meta      (fr_meta),
		.out_s         (fr_s),
		.out_u2        (fr_u2)
	);

	// q = u^2 * 2^30 / s per component
	tfn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (fr_valid),
		.in_meta   (fr_meta),
		.in_s      (fr_s),
		.in_u2     (fr_u2),
		.out_valid (dv_valid),
		.out_meta  (dv_meta),
		.out_q     (dv_q)
	);

	// r = floor(sqrt(q)), which is floor of 2 * u * 2^14 / sqrt(s)
	tfn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (dv_valid),
		.in_meta   (dv_meta),
		.in_q      (dv_q),
		.out_valid (sq_valid),
		.out_meta  (sq_meta),
		.out_r     (sq_r)
	);

	// round half away from zero: k = (r + 1) / 2, then put the sign back; a degenerate word gives zero
	always_comb begin
		for (int l = 0; l < tfn_pkg::LANES; l++) begin
			rnd_c[l] = {1'b0, sq_r[l]} + (tfn_pkg::ROOT_W + 1)'(1);
			if (sq_meta.degen) begin
				nrm_c[l] = '0;
			end else if (sq_meta.neg[l]) begin
				nrm_c[l] = tfn_pkg::OUT_W'(0)
					- tfn_pkg::OUT_W'(rnd_c[l][tfn_pkg::ROOT_W:1]);
			end else begin
				nrm_c[l] = tfn_pkg::OUT_W'(rnd_c[l][tfn_pkg::ROOT_W:1]);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_q    <= nrm_c[0];
			ny_q    <= nrm_c[1];
			nz_q    <= nrm_c[2];
			degen_q <= sq_meta.degen;
			last_q  <= sq_meta.last;
		end
	end

	assign nrm_valid   = vld_q;
	assign normal_x    = nx_q;
	assign normal_y    = ny_q;
	assign normal_z    = nz_q;
	assign degenerate  = degen_q;
	assign last_normal = last_q;

endmodule

`default_nettype wire

// File: rtl/tfn_check.sv
`timescale 1ns / 1ps
`default_nettype none

`include "triangle_face_normal_macros.svh"

module tfn_check (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  tri_valid,
	input  wire logic                                  tri_stall,
	input  wire logic                                  nrm_valid,
	input  wire logic                                  nrm_stall,
	input  wire logic signed [tfn_pkg::OUT_W-1:0]      normal_x,
	input  wire logic signed [tfn_pkg::OUT_W-1:0]      normal_y,
	input  wire logic signed [tfn_pkg::OUT_W-1:0]      normal_z,
	input  wire logic                                  degenerate
);

	// a stalled word stays put
	`TFN_ASSERT_NXT(a_hold, nrm_valid && nrm_stall, nrm_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z), "normal word changed under stall")

	// the triangle side only backs up when the output word is blocked
	`TFN_ASSERT_IMP(a_backpressure, tri_stall, nrm_valid && nrm_stall, "triangle stall without a blocked output")

	// a degenerate triangle gives a zero normal
	`TFN_ASSERT_IMP(a_degen_zero, nrm_valid && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate normal not zero")

	// components never leave plus or minus one
	`TFN_ASSERT_IMP(a_range, nrm_valid, normal_x <= 16'sd16384 && normal_x >= -16'sd16384 && normal_y <= 16'sd16384 && normal_y >= -16'sd16384 && normal_z <= 16'sd16384 && normal_z >= -16'sd16384, "normal component out of range")

endmodule

bind triangle_face_normal tfn_check u_tfn_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.tri_valid  (tri_valid),
	.tri_stall  (tri_stall),
	.nrm_valid  (nrm_valid),
	.nrm_stall  (nrm_stall),
	.normal_x   (normal_x),
	.normal_y   (normal_y),
	.normal_z   (normal_z),
	.degenerate (degenerate)
);

`default_nettype wire
